FILE: hdl/ksm_pkg.sv
// Package for the knob-scanned sine mixer: sizes, register map and quarter-wave sine table.
package ksm_pkg;

   localparam int TABLE_DEPTH  = 512;
   localparam int INDEX_W      = $clog2(TABLE_DEPTH);
   localparam int QUARTER      = TABLE_DEPTH / 4;
   localparam int HALF         = TABLE_DEPTH / 2;
   localparam int LANES        = 4;
   localparam int LANE_W       = $clog2(LANES);
   localparam int KNOB_W       = 12;
   localparam int PHASE_W      = 32;
   localparam int SAMPLE_W     = 16;
   localparam int FRAC_W       = 16;
   localparam int OUT_W        = 12;
   localparam int PROD_W       = SAMPLE_W + FRAC_W + 1;
   localparam int ACC_W        = PROD_W + 1;
   localparam int SHIFT        = 20;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = LANES * OUT_W;
   localparam int CSR_ADDR_W   = LANE_W + 2;
   localparam int CSR_DATA_W   = 32;

   localparam logic [PHASE_W:0]   PHASE_WRAP   = 33'h0_FFFF_FFFF;
   localparam logic [FRAC_W:0]    FRAC_ONE     = 17'h1_0000;
   localparam logic [63:0]        PI_OVER_Q62  = 64'h00C9_0FDA_A221_68C2;
   localparam logic [127:0]       AMPLITUDE    = 128'd32000;

   typedef enum logic [LANE_W-1:0] {
      REG_PHASE_OFFSET_A = 2'd0,
      REG_PHASE_OFFSET_B = 2'd1,
      REG_PHASE_OFFSET_C = 2'd2,
      REG_PHASE_OFFSET_D = 2'd3
   } reg_index_type;

   typedef logic [SAMPLE_W-1:0] qtr_table_type [0:QUARTER];

   function automatic qtr_table_type build_qtr_table();
      qtr_table_type t;
      logic [127:0]  p;
      logic [63:0]   x;
      logic [63:0]   x2;
      logic [63:0]   term;
      logic [63:0]   pos;
      logic [63:0]   neg;
      logic [63:0]   s;
      logic          done;
      for (int q = 0; q <= QUARTER; q++) begin
         if (q == 0) begin
            t[q] = '0;
         end else if (q == QUARTER) begin
            t[q] = SAMPLE_W'(AMPLITUDE);
         end else begin
            x    = PI_OVER_Q62 * 64'(q);
            p    = {64'b0, x} * {64'b0, x};
            x2   = p[125:62];
            term = x;
            pos  = x;
            neg  = '0;
            done = 1'b0;
            for (int k = 1; k < 40; k++) begin
               if (!done) begin
                  p    = {64'b0, term} * {64'b0, x2};
                  term = p[125:62] / 64'((2 * k) * (2 * k + 1));
                  if (term == '0) begin
                     done = 1'b1;
                  end else if ((k % 2) == 1) begin
                     neg = neg + term;
                  end else begin
                     pos = pos + term;
                  end
               end
            end
            s    = pos - neg;
            p    = {64'b0, s} * AMPLITUDE;
            t[q] = p[62+SAMPLE_W-1:62];
         end
      end
      return t;
   endfunction

   localparam qtr_table_type QTR_TABLE = build_qtr_table();

   function automatic logic signed [SAMPLE_W-1:0] sine_at(input logic [INDEX_W-1:0] idx);
      logic [INDEX_W-2:0] q;
      logic [INDEX_W-1:0] mirror;
      logic [SAMPLE_W-1:0] mag;
      q      = idx[INDEX_W-2:0];
      mirror = INDEX_W'(HALF) - {1'b0, q};
      if ({1'b0, q} <= INDEX_W'(QUARTER)) begin
         mag = QTR_TABLE[q];
      end else begin
         mag = QTR_TABLE[mirror[INDEX_W-2:0]];
      end
      if (idx[INDEX_W-1]) begin
         return -signed'(mag);
      end else begin
         return signed'(mag);
      end
   endfunction

endpackage

FILE: hdl/knob_scanned_sine_mixer.sv
// Top level of the knob-scanned sine mixer: phase scaling, sine lookup and interpolation pipeline.
//
// Usage:
//   req_ channel: one knob reading per item in req_tdata[11:0].
//   rsp_ channel: one item per input item with four signed 12-bit sine values
//   (audio_left, audio_right, cv_first, cv_second) packed from the lowest bit up.
//   csr_ port: four 32-bit phase offsets at byte addresses 0, 4, 8 and 12;
//   write them only while no item is in flight.
// Pipeline: input register, phase add and wrap, table lookup, two products per
// lane, sum and shift into the result register. One item is taken every cycle
// while the result register is empty or being taken.
// The whole pipeline advances together whenever the result register is empty or
// being taken, so req_tready follows that condition; when the receiver stalls
// with a result waiting, every stage holds and req_tready drops.
// Reset clears all stage valid flags and the phase offsets to zero. The sine
// table is a constant quarter-wave table and needs no fill after reset.
module knob_scanned_sine_mixer
   import ksm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // knob_level[11:0], zero pad
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // audio_left, audio_right, cv_first, cv_second
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   logic [PHASE_W-1:0]        offset_ff   [LANES];
   logic                      advance;
   reg_index_type             csr_index;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [KNOB_W-1:0]         knob_ff;
   logic [PHASE_W-1:0]        phase_ff    [LANES];
   logic [PHASE_W-1:0]        phase_in    [LANES];
   logic signed [SAMPLE_W-1:0] s1_ff      [LANES];
   logic signed [SAMPLE_W-1:0] s2_ff      [LANES];
   logic [FRAC_W-1:0]         frac_ff     [LANES];
   logic signed [PROD_W-1:0]  p1_ff       [LANES];
   logic signed [PROD_W-1:0]  p2_ff       [LANES];
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_in;

   logic [KNOB_W+PHASE_W-1:0] step_full;
   logic [PHASE_W-1:0]        step;

   assign advance    = !v5_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_prdata = offset_ff[csr_index];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LANES; j++) begin
            offset_ff[j] <= '0;
         end
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         offset_ff[csr_index] <= csr_pwdata;
      end
   end

   // knob * (2^32 - 1) >> 12
   assign step_full = {knob_ff, {PHASE_W{1'b0}}} - (KNOB_W+PHASE_W)'(knob_ff);
   assign step      = step_full[KNOB_W+PHASE_W-1:KNOB_W];

   always_comb begin
      logic [PHASE_W:0] sum;
      for (int j = 0; j < LANES; j++) begin
         sum = {1'b0, offset_ff[j]} + {1'b0, step};
         if (sum >= PHASE_WRAP) begin
            sum = sum - PHASE_WRAP;
         end
         phase_in[j] = sum[PHASE_W-1:0];
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] acc;
      rsp_data_in = '0;
      for (int j = 0; j < LANES; j++) begin
         acc = ACC_W'(p1_ff[j]) + ACC_W'(p2_ff[j]);
         rsp_data_in[j*OUT_W +: OUT_W] = acc[SHIFT+OUT_W-1:SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [INDEX_W-1:0] idx;
      if (advance) begin
         knob_ff <= req_tdata[KNOB_W-1:0];
         for (int j = 0; j < LANES; j++) begin
            phase_ff[j] <= phase_in[j];
            idx          = phase_ff[j][PHASE_W-1 -: INDEX_W];
            s1_ff[j]    <= sine_at(idx);
            s2_ff[j]    <= sine_at(idx + INDEX_W'(1));
            frac_ff[j]  <= phase_ff[j][PHASE_W-INDEX_W-1 -: FRAC_W];
            p2_ff[j]    <= s2_ff[j] * signed'({1'b0, frac_ff[j]});
            p1_ff[j]    <= s1_ff[j] * signed'({1'b0, FRAC_ONE - {1'b0, frac_ff[j]}});
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: hdl/ksm_checker.sv
// Port-level checker for the knob-scanned sine mixer, bound to the top level.
module ksm_checker
   import ksm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tready,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata    // audio_left, audio_right, cv_first, cv_second
);

   localparam logic signed [OUT_W-1:0] OUT_MAX = 12'sd2000;
   localparam logic signed [OUT_W-1:0] OUT_MIN = -12'sd2000;

   logic in_range;

   always_comb begin
      logic signed [OUT_W-1:0] v;
      in_range = 1'b1;
      for (int j = 0; j < LANES; j++) begin
         v = signed'(rsp_tdata[j*OUT_W +: OUT_W]);
         if (v > OUT_MAX || v < OUT_MIN) begin
            in_range = 1'b0;
         end
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled with free result register");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> in_range)
      else $error("sine value out of range");

endmodule

bind knob_scanned_sine_mixer ksm_checker u_ksm_checker (.*);
